[hw/rtl/msvm_pkg.sv]
package msvm_pkg;

  localparam int WINDOW_LOG2    = 5;
  localparam int WINDOW_SAMPLES = 1 << WINDOW_LOG2;
  localparam int SAMPLE_BITS    = 10;
  localparam int COUNT_BITS     = WINDOW_LOG2;
  localparam int SUM_BITS       = 2 * SAMPLE_BITS + WINDOW_LOG2;
  localparam int MEAN_BITS      = SUM_BITS - WINDOW_LOG2;
  localparam int MEAN_DIV_LOG2  = 3;
  localparam int DIVISOR_BITS   = MEAN_BITS - MEAN_DIV_LOG2;
  localparam int REG_BITS       = 16;
  localparam int SCALE_LOG2     = 9;
  localparam int NUM_BITS       = REG_BITS + SCALE_LOG2;
  localparam int STEP_BITS      = $clog2(NUM_BITS);
  localparam int PROD_BITS      = MEAN_BITS + REG_BITS;
  localparam int VOLT_SHIFT     = MEAN_DIV_LOG2 + SCALE_LOG2;
  localparam int Q_BITS         = PROD_BITS - VOLT_SHIFT;

  localparam int IN_DATA_BITS   = 16;
  localparam int OUT_DATA_BITS  = 48;
  localparam int CFG_INDEX_BITS = 1;

  localparam logic [23:0]         RAW_LIMIT   = 24'hFFFFFF;
  localparam logic [REG_BITS-1:0] SAT16       = 16'hFFFF;
  localparam logic [REG_BITS-1:0] GAIN_RESET  = 16'h01A0;

  localparam logic [CFG_INDEX_BITS-1:0] REG_GAIN_FACTOR     = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_REFERENCE_LEVEL = 1'b1;

  typedef struct packed {
    logic accept;
    logic close;
    logic mul_en;
    logic div_step;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic last_sample;
    logic calib;
    logic out_free;
  } ctrl_status_t;

endpackage

[hw/rtl/mean_square_voltage_meter.sv]
// accepts one sample per cycle while the input is ready; 32 samples form a window
// after a window's last sample, the input stalls while the result is computed: a
// multiply in measure mode, or a multiply then a 25-step divider in calibrate mode
// the result is registered after the multiply (measure) or the divider (calibrate)
// both stretch while the previous result still waits in the output register
// sync active-high reset clears sum, count, output valid, reference; gain to 16'h01A0
module mean_square_voltage_meter (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [msvm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [msvm_pkg::REG_BITS-1:0]       cfg_data,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [msvm_pkg::IN_DATA_BITS-1:0]   s_tdata,  // sample
  input  logic                                s_tuser,  // mode
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // voltage, new_factor, overflow, divide_fault, noise_byte
  output logic [msvm_pkg::OUT_DATA_BITS-1:0]  m_tdata,
  output logic                                m_tuser   // was_calibration
);
  import msvm_pkg::*;

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  msvm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  msvm_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

[hw/rtl/msvm_ctrl.sv]
module msvm_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  msvm_pkg::ctrl_status_t status,
  output msvm_pkg::ctrl_cmd_t    cmd
);
  import msvm_pkg::*;

  typedef enum logic [1:0] {
    ST_ACCUM,
    ST_MUL,
    ST_DIV,
    ST_FINISH
  } state_t;

  state_t               state;
  logic [STEP_BITS-1:0] step;

  assign s_tready = (state == ST_ACCUM);

  always_comb begin
    cmd          = '0;
    cmd.accept   = s_tvalid && s_tready;
    cmd.close    = cmd.accept && status.last_sample;
    cmd.mul_en   = (state == ST_MUL);
    cmd.div_step = (state == ST_DIV);
    cmd.out_load = (state == ST_FINISH) && status.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_ACCUM;
      step  <= '0;
    end else begin
      case (state)
        ST_ACCUM: begin
          if (cmd.close) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          step <= '0;
          if (status.calib) begin
            state <= ST_DIV;
          end else begin
            state <= ST_FINISH;
          end
        end
        ST_DIV: begin
          step <= step + 1'b1;
          if (step == STEP_BITS'(NUM_BITS - 1)) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (status.out_free) begin
            state <= ST_ACCUM;
          end
        end
        default: begin
          state <= ST_ACCUM;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_close_blocks: assert property (@(posedge clk) disable iff (rst)
    cmd.close |=> !s_tready)
    else $error("input still ready after window close");

  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (step < STEP_BITS'(NUM_BITS)))
    else $error("divide step counter out of range");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> status.out_free)
    else $error("output register loaded while full");

  a_finish_entry: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_FINISH) && ($past(state) != ST_FINISH))
      |-> ($past(state) == ST_MUL || $past(state) == ST_DIV))
    else $error("finish entered without computation");
`endif

endmodule

[hw/rtl/msvm_datapath.sv]
module msvm_datapath (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     cfg_we,
  input  logic [msvm_pkg::CFG_INDEX_BITS-1:0]      cfg_index,
  input  logic [msvm_pkg::REG_BITS-1:0]            cfg_data,
  input  logic [msvm_pkg::IN_DATA_BITS-1:0]        s_tdata,
  input  logic                                     s_tuser,
  output logic                                     m_tvalid,
  input  logic                                     m_tready,
  output logic [msvm_pkg::OUT_DATA_BITS-1:0]       m_tdata,
  output logic                                     m_tuser,
  input  msvm_pkg::ctrl_cmd_t                      cmd,
  output msvm_pkg::ctrl_status_t                   status
);
  import msvm_pkg::*;

  logic [REG_BITS-1:0]     gain_factor;
  logic [REG_BITS-1:0]     reference_level;
  logic [SUM_BITS-1:0]     square_sum;
  logic [COUNT_BITS-1:0]   sample_count;
  logic [SUM_BITS-1:0]     win_sum;
  logic                    calib;
  logic [PROD_BITS-1:0]    product;
  logic [DIVISOR_BITS-1:0] rem;
  logic [NUM_BITS-1:0]     quo;
  logic                    out_valid;

  logic [SAMPLE_BITS-1:0]    sample;
  logic [2*SAMPLE_BITS-1:0]  square;
  logic [SUM_BITS-1:0]       sum_add;
  logic [MEAN_BITS-1:0]      mean;
  logic [DIVISOR_BITS-1:0]   divisor;
  logic [DIVISOR_BITS:0]     rem_shift;
  logic [DIVISOR_BITS:0]     rem_diff;
  logic                      rem_ge;
  logic [Q_BITS-1:0]         q;
  logic                      q_big;
  logic                      quo_big;
  logic                      ovf_raw;
  logic                      fault;
  logic                      ovf;
  logic [REG_BITS-1:0]       volt;
  logic [REG_BITS-1:0]       factor;

  assign sample  = s_tdata[SAMPLE_BITS-1:0];
  assign square  = (2*SAMPLE_BITS)'(sample) * (2*SAMPLE_BITS)'(sample);
  assign sum_add = square_sum + SUM_BITS'(square);

  assign mean    = win_sum[SUM_BITS-1:WINDOW_LOG2];
  assign divisor = win_sum[SUM_BITS-1:WINDOW_LOG2+MEAN_DIV_LOG2];

  assign rem_shift = {rem, quo[NUM_BITS-1]};
  assign rem_diff  = rem_shift - {1'b0, divisor};
  assign rem_ge    = (rem_shift >= {1'b0, divisor});

  assign status.last_sample = (sample_count == COUNT_BITS'(WINDOW_SAMPLES - 1));
  assign status.calib       = calib;
  assign status.out_free    = !out_valid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_factor     <= GAIN_RESET;
      reference_level <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GAIN_FACTOR:     gain_factor     <= cfg_data;
        REG_REFERENCE_LEVEL: reference_level <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      square_sum   <= '0;
      sample_count <= '0;
    end else if (cmd.accept) begin
      if (cmd.close) begin
        square_sum   <= '0;
        sample_count <= '0;
      end else begin
        square_sum   <= sum_add;
        sample_count <= sample_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.close) begin
      win_sum <= sum_add;
      calib   <= s_tuser;
      rem     <= '0;
      quo     <= {reference_level, SCALE_LOG2'(0)};
    end else if (cmd.div_step) begin
      rem <= rem_ge ? rem_diff[DIVISOR_BITS-1:0] : rem_shift[DIVISOR_BITS-1:0];
      quo <= {quo[NUM_BITS-2:0], rem_ge};
    end
    if (cmd.mul_en) begin
      product <= PROD_BITS'(mean) * PROD_BITS'(gain_factor);
    end
  end

  assign q       = product[PROD_BITS-1:VOLT_SHIFT];
  assign q_big   = (q[Q_BITS-1:REG_BITS] != '0);
  assign quo_big = (quo[NUM_BITS-1:REG_BITS] != '0);
  assign ovf_raw = (win_sum > SUM_BITS'(RAW_LIMIT));
  assign fault   = calib && (divisor == '0);

  always_comb begin
    if (calib) begin
      volt   = '0;
      ovf    = ovf_raw;
      factor = (fault || quo_big) ? SAT16 : quo[REG_BITS-1:0];
    end else begin
      ovf    = ovf_raw || q_big;
      volt   = ovf ? SAT16 : q[REG_BITS-1:0];
      factor = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= {6'b0, win_sum[7:0], fault, ovf, factor, volt};
      m_tuser <= calib;
    end
  end

  assign m_tvalid = out_valid;

endmodule
